// ===== src/static_linked_list_engine_defines.svh =====
// assertion macros for the static linked list engine
// used by static_linked_list_engine.sv, expects clk and arst_n in scope
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// property checked at every clock edge outside reset
`define SLL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked outside reset
`define SLL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/sll_pkg.sv =====
// types and constants for the static linked list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

	localparam int NODES  = 64;
	localparam int IDX_W  = 6;
	localparam int DATA_W = 32;
	localparam int OP_W   = 4;

	localparam logic [IDX_W-1:0] HEAD_NODE = IDX_W'(NODES - 1);
	localparam logic [IDX_W-1:0] MAX_ELEMS = IDX_W'(NODES - 2);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT  = 4'd0,
		OP_APPEND  = 4'd1,
		OP_DEL_AT  = 4'd2,
		OP_DEL_VAL = 4'd3,
		OP_GET     = 4'd4,
		OP_LOCATE  = 4'd5,
		OP_PREV    = 4'd6,
		OP_NEXT    = 4'd7,
		OP_CLEAR   = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_NEXT,
		ST_ALLOC,
		ST_ALLOC2,
		ST_LINK,
		ST_FREE,
		ST_DONE
	} state_t;

	// link of a node that has not been written since reset
	function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] a);
		logic [IDX_W-1:0] r;
		r = '0;
		if (a < MAX_ELEMS)
			r = a + 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/static_linked_list_engine.sv =====
// static linked list engine: cursor list in a node store with a free list
// depends on sll_pkg and static_linked_list_engine_defines.svh
//
// usage
//   input channel in_valid/in_ready carries op, position and value; one item
//   is taken only while the engine is idle, and each item yields exactly one
//   result item on out_valid/out_ready (ok, value_out, node_index, list_length)
//   clear and rejected items go from idle straight to done; append passes
//   through alloc, alloc2 and link; positional and value operations walk the
//   list one node per cycle through the registered node memory read port,
//   then insert relinks through alloc, alloc2 and link, delete through link
//   and free; a new item is taken only after the last one has left done, and
//   it is accepted while a finished result still waits in the output register
//   reset: the list is empty and every node from 1 to 62 is on the free list;
//   per-node valid bits stand in for the reset links, no clearing pass runs
//   stall: when out_ready is low the result holds and a finished second item
//   waits in its last state until the output register frees up
`timescale 1ns / 1ps
`default_nettype none
`include "static_linked_list_engine_defines.svh"

module static_linked_list_engine
	import sll_pkg::*;
(
	input  wire  logic                     clk,
	input  wire  logic                     arst_n,
	input  wire  logic                     in_valid,
	output logic                           in_ready,
	input  wire  logic [OP_W-1:0]          op,
	input  wire  logic [IDX_W-1:0]         position,
	input  wire  logic signed [DATA_W-1:0] value,
	output logic                           out_valid,
	input  wire  logic                     out_ready,
	output logic                           ok,
	output logic signed [DATA_W-1:0]       value_out,
	output logic [IDX_W-1:0]               node_index,
	output logic [IDX_W-1:0]               list_length
);

	state_t state_q, state_d;

	logic [DATA_W-1:0] data_mem [NODES];
	logic [IDX_W-1:0]  link_mem [NODES];
	logic [NODES-1:0]  lv_q;

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  steps_q, prev_q, cur_q, nj_q;
	logic [IDX_W-1:0]  fhead_q, lhead_q, tail_q, cnt_q;
	logic [DATA_W-1:0] pdata_q, rdata_q;
	logic [IDX_W-1:0]  link_rd_q, raddr_q;
	logic              lvr_q;
	logic              res_ok_q;
	logic [DATA_W-1:0] res_val_q;
	logic [IDX_W-1:0]  res_node_q;
	logic              out_valid_q, ok_q;
	logic [DATA_W-1:0] value_out_q;
	logic [IDX_W-1:0]  node_index_q, list_length_q;

	logic [IDX_W-1:0]  rlink, ra;
	logic              accept, match, pos_mode, hit, pos_ok, ins_ok, app_ok, out_free;
	logic              lw_en, lw_mem_en, dw_en;
	logic [IDX_W-1:0]  lw_addr, lw_data;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign rlink = (raddr_q == '0) ? fhead_q :
	               (raddr_q == HEAD_NODE) ? lhead_q :
	               lvr_q ? link_rd_q : reset_link(raddr_q);
	assign match = (rdata_q == val_q);

	assign pos_ok = (position != '0) && (position <= cnt_q);
	assign ins_ok = (position != '0) && ({1'b0, position} <= ({1'b0, cnt_q} + 1'b1))
	                && (fhead_q != '0);
	assign app_ok = (cnt_q < MAX_ELEMS) && (fhead_q != '0);

	assign pos_mode = (op_q == OP_INSERT) || (op_q == OP_DEL_AT) || (op_q == OP_GET);

	always_comb begin
		if (pos_mode)
			hit = (steps_q == '0);
		else if (cur_q == '0)
			hit = 1'b1;
		else if (op_q == OP_PREV)
			hit = match && (prev_q != HEAD_NODE);
		else
			hit = match;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_INSERT:  state_d = ins_ok ? ST_WALK : ST_DONE;
						OP_APPEND:  state_d = app_ok ? ST_ALLOC : ST_DONE;
						OP_DEL_AT,
						OP_GET:     state_d = pos_ok ? ST_WALK : ST_DONE;
						OP_DEL_VAL,
						OP_LOCATE,
						OP_PREV,
						OP_NEXT:    state_d = ST_WALK;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_WALK: begin
				if (hit) begin
					case (op_q)
						OP_INSERT:  state_d = ST_ALLOC;
						OP_DEL_AT,
						OP_DEL_VAL: state_d = (cur_q != '0) ? ST_LINK : ST_DONE;
						OP_NEXT:    state_d = (cur_q != '0 && rlink != '0) ? ST_NEXT : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_NEXT:   state_d = ST_DONE;
			ST_ALLOC:  state_d = ST_ALLOC2;
			ST_ALLOC2: state_d = ST_LINK;
			ST_LINK:   state_d = (op_q == OP_INSERT || op_q == OP_APPEND) ? ST_DONE : ST_FREE;
			ST_FREE:   state_d = ST_DONE;
			ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		lw_en   = 1'b0;
		lw_addr = '0;
		lw_data = '0;
		dw_en   = 1'b0;
		case (state_q)
			ST_IDLE:   ra = lhead_q;
			ST_ALLOC:  ra = fhead_q;
			default:   ra = rlink;
		endcase
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_CLEAR && lhead_q != '0) begin
					lw_en   = 1'b1;
					lw_addr = tail_q;
					lw_data = fhead_q;
				end
			end
			ST_ALLOC2: begin
				lw_en   = 1'b1;
				lw_addr = fhead_q;
				lw_data = cur_q;
				dw_en   = 1'b1;
			end
			ST_LINK: begin
				lw_en   = 1'b1;
				lw_addr = prev_q;
				lw_data = nj_q;
			end
			ST_FREE: begin
				lw_en   = 1'b1;
				lw_addr = cur_q;
				lw_data = fhead_q;
			end
			default: begin
				lw_en = 1'b0;
			end
		endcase
		lw_mem_en = lw_en && (lw_addr != HEAD_NODE);
	end

	always_ff @(posedge clk) begin
		rdata_q   <= data_mem[ra];
		link_rd_q <= link_mem[ra];
		if (dw_en)
			data_mem[fhead_q] <= val_q;
		if (lw_mem_en)
			link_mem[lw_addr] <= lw_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q    <= '0;
			raddr_q <= '0;
			lvr_q   <= 1'b0;
		end else begin
			raddr_q <= ra;
			lvr_q   <= lv_q[ra];
			if (lw_mem_en)
				lv_q[lw_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			steps_q    <= '0;
			prev_q     <= HEAD_NODE;
			cur_q      <= '0;
			nj_q       <= '0;
			pdata_q    <= '0;
			fhead_q    <= IDX_W'(1);
			lhead_q    <= '0;
			tail_q     <= HEAD_NODE;
			cnt_q      <= '0;
			res_ok_q   <= 1'b0;
			res_val_q  <= '1;
			res_node_q <= '0;
		end else begin
			state_q <= state_d;
			if (lw_en && lw_addr == HEAD_NODE)
				lhead_q <= lw_data;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_ok_q   <= 1'b0;
						res_val_q  <= '1;
						res_node_q <= '0;
						steps_q    <= position - 1'b1;
						if (op == OP_APPEND) begin
							prev_q <= tail_q;
							cur_q  <= '0;
						end else begin
							prev_q <= HEAD_NODE;
							cur_q  <= lhead_q;
						end
						if (op == OP_CLEAR) begin
							if (lhead_q != '0) begin
								fhead_q <= lhead_q;
								lhead_q <= '0;
							end
							tail_q    <= HEAD_NODE;
							cnt_q     <= '0;
							res_ok_q  <= 1'b1;
							res_val_q <= '0;
						end
					end
				end
				ST_WALK: begin
					if (hit) begin
						case (op_q)
							OP_GET: begin
								res_ok_q  <= 1'b1;
								res_val_q <= rdata_q;
							end
							OP_DEL_AT,
							OP_DEL_VAL,
							OP_LOCATE: begin
								if (cur_q != '0) begin
									nj_q      <= rlink;
									res_ok_q  <= 1'b1;
									res_val_q <= rdata_q;
									if (op_q == OP_LOCATE)
										res_node_q <= cur_q;
								end
							end
							OP_PREV: begin
								if (cur_q != '0) begin
									res_ok_q  <= 1'b1;
									res_val_q <= pdata_q;
								end
							end
							default: begin
								nj_q <= nj_q;
							end
						endcase
					end else begin
						prev_q  <= cur_q;
						pdata_q <= rdata_q;
						cur_q   <= rlink;
						steps_q <= steps_q - 1'b1;
					end
				end
				ST_NEXT: begin
					res_ok_q  <= 1'b1;
					res_val_q <= rdata_q;
				end
				ST_ALLOC2: begin
					fhead_q    <= rlink;
					nj_q       <= fhead_q;
					res_ok_q   <= 1'b1;
					res_val_q  <= '0;
					res_node_q <= fhead_q;
					cnt_q      <= cnt_q + 1'b1;
					if (cur_q == '0)
						tail_q <= fhead_q;
				end
				ST_LINK: begin
					if (op_q == OP_DEL_AT || op_q == OP_DEL_VAL) begin
						if (nj_q == '0)
							tail_q <= prev_q;
					end
				end
				ST_FREE: begin
					fhead_q <= cur_q;
					if (cnt_q != '0)
						cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					nj_q <= nj_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			ok_q          <= res_ok_q;
			value_out_q   <= res_val_q;
			node_index_q  <= res_node_q;
			list_length_q <= cnt_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign value_out   = value_out_q;
	assign node_index  = node_index_q;
	assign list_length = list_length_q;

	`SLL_ASSERT(a_cnt_range, cnt_q <= MAX_ELEMS, "element count beyond capacity")
	`SLL_ASSERT_IMP(a_free_full, state_q == ST_IDLE,
		(fhead_q == '0) == (cnt_q == MAX_ELEMS), "free list and count disagree")
	`SLL_ASSERT_IMP(a_empty_list, state_q == ST_IDLE && cnt_q == '0,
		lhead_q == '0 && tail_q == HEAD_NODE, "empty list with live head or tail")
	`SLL_ASSERT_IMP(a_fail_out, out_valid && !ok,
		value_out == '1 && node_index == '0, "failed item with payload")

endmodule

`default_nettype wire
